/* rtl/core/battery_charge_estimator_defines.svh */
// assertion macros used by the battery charge estimator datapath
`ifndef BATTERY_CHARGE_ESTIMATOR_DEFINES_SVH
`define BATTERY_CHARGE_ESTIMATOR_DEFINES_SVH

// same-cycle implication, checked on i_clk, off while i_rst_n is low
`define BCE_CHECK_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bce check failed");

// next-cycle implication, checked on i_clk, off while i_rst_n is low
`define BCE_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bce check failed");

`endif

/* rtl/core/bce_pkg.sv */
// shared types, constants and lookup tables of the battery charge estimator
package bce_pkg;

    // field widths
    localparam int ADC_W      = 12;
    localparam int CHARGE_W   = 14;
    localparam int PCT_W      = 7;
    localparam int MV_W       = 15;
    localparam int STATUS_W   = 2;
    localparam int THR_W      = 14;
    localparam int OFS_W      = 10;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;

    // stream widths
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_FIELDS_W  = ADC_W + CHARGE_W + PCT_W + MV_W + STATUS_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // sample ring
    localparam int SAMPLE_DEPTH = 16;
    localparam int SLOT_W       = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);
    localparam int SUM_W        = ADC_W + CNT_W;

    // charge table
    localparam int TABLE_POINTS = 26;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int SPAN_W       = 14;
    localparam int MUL_W        = ADC_W + SPAN_W;
    localparam int CHARGE_FULL  = 10000;
    localparam int PCT_SCALE    = 100;

    // shared divider
    localparam int DIV_W     = 28;
    localparam int DVS_W     = 12;
    localparam int STEP_W    = $clog2(DIV_W / 2 + 1);
    localparam int MEAN_BITS = ((SUM_W + 1) / 2) * 2;
    // the table keeps the rounded interpolation dividend below 2^16
    localparam int CHG_BITS  = 16;
    localparam int MV_BITS   = DIV_W;

    // linear voltage map, rounded half up: q = (2*num + den) / (2*den)
    localparam int MAP_ADC_LO = 2498;
    localparam int MAP_ADC_HI = 3720;
    localparam int MAP_MV_LO  = 17000;
    localparam int MAP_MV_HI  = 25200;
    localparam int MV_DEN     = MAP_ADC_HI - MAP_ADC_LO;
    localparam int MV_SLOPE2  = 2 * (MAP_MV_HI - MAP_MV_LO);
    localparam int MV_BIAS    = 2 * (MAP_MV_LO * MV_DEN - MAP_ADC_LO * (MAP_MV_HI - MAP_MV_LO))
                                + MV_DEN;
    localparam int MV_DVS     = 2 * MV_DEN;
    localparam int MV_DVD_W   = 27;

    // whole percent: (x + 50) / 100 as a reciprocal multiply
    localparam int PCT_RND    = 50;
    localparam int PCT_RECIP  = 41944;
    localparam int PCT_SHIFT  = 22;
    localparam int PCT_PROD_W = 31;

    // register reset values
    localparam int LOW_THR_RST  = 2000;
    localparam int CRIT_THR_RST = 1800;
    localparam int VOLT_OFS_RST = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_OFS = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL   = 2'd0,
        ST_LOW      = 2'd1,
        ST_CRITICAL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_CHG,
        DIV_MV
    } t_div_op;

    // controller to datapath commands
    typedef struct packed {
        logic    accept;
        logic    upd;
        logic    div_start;
        t_div_op div_op;
        logic    mean_load;
        logic    seg_load;
        logic    chg_load;
        logic    mv_load;
        logic    out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

    // converter reading of each table point
    function automatic logic [ADC_W-1:0] tab_adc(input logic [IDX_W-1:0] idx);
        logic [ADC_W-1:0] v;
        unique case (idx)
            5'd0:    v = 12'd2802;
            5'd1:    v = 12'd2839;
            5'd2:    v = 12'd2876;
            5'd3:    v = 12'd2913;
            5'd4:    v = 12'd2950;
            5'd5:    v = 12'd2987;
            5'd6:    v = 12'd3024;
            5'd7:    v = 12'd3061;
            5'd8:    v = 12'd3098;
            5'd9:    v = 12'd3135;
            5'd10:   v = 12'd3172;
            5'd11:   v = 12'd3209;
            5'd12:   v = 12'd3246;
            5'd13:   v = 12'd3283;
            5'd14:   v = 12'd3320;
            5'd15:   v = 12'd3357;
            5'd16:   v = 12'd3394;
            5'd17:   v = 12'd3431;
            5'd18:   v = 12'd3468;
            5'd19:   v = 12'd3505;
            5'd20:   v = 12'd3542;
            5'd21:   v = 12'd3580;
            5'd22:   v = 12'd3620;
            5'd23:   v = 12'd3660;
            5'd24:   v = 12'd3700;
            5'd25:   v = 12'd3720;
            default: v = 12'd3720;
        endcase
        return v;
    endfunction

    // percent of each table point
    function automatic logic [PCT_W-1:0] tab_pct(input logic [IDX_W-1:0] idx);
        logic [PCT_W-1:0] v;
        unique case (idx)
            5'd0:    v = 7'd0;
            5'd1:    v = 7'd5;
            5'd2:    v = 7'd10;
            5'd3:    v = 7'd15;
            5'd4:    v = 7'd20;
            5'd5:    v = 7'd25;
            5'd6:    v = 7'd30;
            5'd7:    v = 7'd35;
            5'd8:    v = 7'd40;
            5'd9:    v = 7'd45;
            5'd10:   v = 7'd50;
            5'd11:   v = 7'd55;
            5'd12:   v = 7'd60;
            5'd13:   v = 7'd65;
            5'd14:   v = 7'd70;
            5'd15:   v = 7'd75;
            5'd16:   v = 7'd80;
            5'd17:   v = 7'd85;
            5'd18:   v = 7'd90;
            5'd19:   v = 7'd95;
            default: v = 7'd100;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/battery_charge_estimator.sv */
// top level of the battery charge estimator
// a request is taken only while the controller is idle, so the next request waits until
//   the last result is loaded; the shared divider retires two quotient bits per cycle
//   over 9 + 8 + 14 steps (mean, charge, voltage)
// a finished result waits in the output register while the next request is taken
// reset is synchronous active low: ring pointer, fill flag, running sum and
//   registers return to their defaults at once; the sample store is not cleared
module battery_charge_estimator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side, tdata: adc_sample[11:0], zero padding[15:12]
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [bce_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // master side, tdata: filtered_adc[11:0], charge_hundredths[25:12],
    // charge_percent[32:26], voltage_mv[47:33], charge_status[49:48], zeros[55:50]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [bce_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // register write port
    input  logic                              i_cfg_wr_en,
    input  logic [bce_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bce_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import bce_pkg::*;

    t_cmd                cmd;
    t_sts                sts;
    logic [ADC_W-1:0]    filtered_adc;
    logic [CHARGE_W-1:0] charge_hundredths;
    logic [PCT_W-1:0]    charge_percent;
    logic [MV_W-1:0]     voltage_mv;
    logic [STATUS_W-1:0] charge_status;

    bce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bce_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_sample            (i_s_axis_tdata[ADC_W-1:0]),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_out_ready         (i_m_axis_tready),
        .o_out_valid         (o_m_axis_tvalid),
        .o_filtered_adc      (filtered_adc),
        .o_charge_hundredths (charge_hundredths),
        .o_charge_percent    (charge_percent),
        .o_voltage_mv        (voltage_mv),
        .o_charge_status     (charge_status)
    );

    // result packing, first field in the low bits
    assign o_m_axis_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), charge_status, voltage_mv,
                             charge_percent, charge_hundredths, filtered_adc};

endmodule

/* rtl/core/bce_div.sv */
// shared restoring divider, two quotient bits per cycle
module bce_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bce_pkg::DIV_W-1:0]   i_dividend,
    input  logic [bce_pkg::DVS_W-1:0]   i_divisor,
    input  logic [bce_pkg::STEP_W-1:0]  i_steps,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [bce_pkg::DIV_W-1:0]   o_quotient
);
    import bce_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DIV_W-1:0]  n_quo;
    logic [DVS_W-1:0]  n_rem;

    // two shift-compare-subtract steps; the dividend is left aligned in r_quo
    always_comb begin
        logic [DVS_W:0] rr;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            rr    = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (rr >= {1'b0, r_dvs}) begin
                rr       = rr - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = rr[DVS_W-1:0];
        end
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/bce_dp.sv */
// datapath: sample ring, running sum, interpolation, voltage map and output register
`include "battery_charge_estimator_defines.svh"

module bce_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bce_pkg::t_cmd                  i_cmd,
    output bce_pkg::t_sts                  o_sts,
    input  logic [bce_pkg::ADC_W-1:0]      i_sample,
    input  logic                           i_cfg_wr_en,
    input  logic [bce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bce_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [bce_pkg::ADC_W-1:0]      o_filtered_adc,
    output logic [bce_pkg::CHARGE_W-1:0]   o_charge_hundredths,
    output logic [bce_pkg::PCT_W-1:0]      o_charge_percent,
    output logic [bce_pkg::MV_W-1:0]       o_voltage_mv,
    output logic [bce_pkg::STATUS_W-1:0]   o_charge_status
);
    import bce_pkg::*;

    // configuration registers
    logic [THR_W-1:0] r_low_thr;
    logic [THR_W-1:0] r_crit_thr;
    logic [OFS_W-1:0] r_volt_ofs;

    // ring state
    logic [ADC_W-1:0]  r_mem [SAMPLE_DEPTH];
    logic [ADC_W-1:0]  r_rd_data;
    logic [ADC_W-1:0]  r_sample;
    logic [SLOT_W-1:0] r_slot;
    logic              r_filled;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  count;

    // working registers
    logic [ADC_W-1:0]     r_mean;
    logic [CHG_BITS-1:0]  r_chg_dvd;
    logic [DVS_W-1:0]     r_chg_dvs;
    logic [CHARGE_W-1:0]  r_chg_base;
    logic                 r_below;
    logic                 r_above;
    logic [MV_DVD_W-1:0]  r_mv_dvd;
    logic [CHARGE_W-1:0]  r_charge;
    logic [MV_W-1:0]      r_mv;
    logic [PCT_W-1:0]     r_pct;

    // output register
    logic                 r_out_valid;
    logic [ADC_W-1:0]     r_o_adc;
    logic [CHARGE_W-1:0]  r_o_charge;
    logic [PCT_W-1:0]     r_o_pct;
    logic [MV_W-1:0]      r_o_mv;
    t_status              r_o_status;

    // divider hookup
    logic [DIV_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic [STEP_W-1:0] div_steps;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    // segment lookup
    logic [IDX_W-1:0]   seg_idx;
    logic [IDX_W-1:0]   seg_prev;
    logic [ADC_W-1:0]   seg_rl;
    logic [ADC_W-1:0]   seg_rh;
    logic [PCT_W-1:0]   seg_pl;
    logic [PCT_W-1:0]   seg_ph;
    logic [ADC_W-1:0]   seg_den;
    logic [ADC_W-1:0]   seg_diff;
    logic [SPAN_W-1:0]  seg_span;
    logic [MUL_W-1:0]   seg_num;
    logic [MUL_W:0]     seg_dvd;

    // result shaping
    logic [CHARGE_W:0]    chg_sum;
    logic [CHARGE_W-1:0]  chg_val;
    logic [MV_W-1:0]      mv_q;
    logic [CHARGE_W:0]    pct_in;
    logic [PCT_PROD_W-1:0] pct_prod;
    t_status              status;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= THR_W'(LOW_THR_RST);
            r_crit_thr <= THR_W'(CRIT_THR_RST);
            r_volt_ofs <= OFS_W'(VOLT_OFS_RST);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LOW_THR:  r_low_thr  <= i_cfg_wdata[THR_W-1:0];
                CFG_CRIT_THR: r_crit_thr <= i_cfg_wdata[THR_W-1:0];
                CFG_VOLT_OFS: r_volt_ofs <= i_cfg_wdata[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // sample store: read the slot about to be overwritten, then write it
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[r_slot];
            r_sample  <= i_sample;
        end
        if (i_cmd.upd) begin
            r_mem[r_slot] <= r_sample;
        end
    end

    // write pointer, fill flag and running sum of the stored samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_filled <= 1'b0;
            r_sum    <= '0;
        end else if (i_cmd.upd) begin
            r_sum <= r_sum + SUM_W'(r_sample) - (r_filled ? SUM_W'(r_rd_data) : '0);
            if (r_slot == SLOT_W'(SAMPLE_DEPTH - 1)) begin
                r_slot   <= '0;
                r_filled <= 1'b1;
            end else begin
                r_slot <= r_slot + SLOT_W'(1);
            end
        end
    end

    assign count = r_filled ? CNT_W'(SAMPLE_DEPTH) : CNT_W'(r_slot);

    // divider operand select, dividends left aligned to their step count
    always_comb begin
        case (i_cmd.div_op)
            DIV_MEAN: begin
                div_dvd   = DIV_W'(r_sum) << (DIV_W - MEAN_BITS);
                div_dvs   = DVS_W'(count);
                div_steps = STEP_W'(MEAN_BITS / 2);
            end
            DIV_CHG: begin
                div_dvd   = DIV_W'(r_chg_dvd) << (DIV_W - CHG_BITS);
                div_dvs   = r_chg_dvs;
                div_steps = STEP_W'(CHG_BITS / 2);
            end
            DIV_MV: begin
                div_dvd   = DIV_W'(r_mv_dvd) << (DIV_W - MV_BITS);
                div_dvs   = DVS_W'(MV_DVS);
                div_steps = STEP_W'(MV_BITS / 2);
            end
            default: begin
                div_dvd   = '0;
                div_dvs   = DVS_W'(1);
                div_steps = STEP_W'(1);
            end
        endcase
    end

    bce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // first table point from index 1 on at or above the mean, else the last point
    always_comb begin
        seg_idx = IDX_W'(TABLE_POINTS - 1);
        for (int i = TABLE_POINTS - 1; i >= 1; i--) begin
            if (r_mean <= tab_adc(IDX_W'(i))) begin
                seg_idx = IDX_W'(i);
            end
        end
    end

    // interpolation operands for the segment
    assign seg_prev = seg_idx - IDX_W'(1);
    assign seg_rl   = tab_adc(seg_prev);
    assign seg_rh   = tab_adc(seg_idx);
    assign seg_pl   = tab_pct(seg_prev);
    assign seg_ph   = tab_pct(seg_idx);
    assign seg_den  = seg_rh - seg_rl;
    assign seg_diff = r_mean - seg_rl;
    assign seg_span = SPAN_W'(seg_ph - seg_pl) * SPAN_W'(PCT_SCALE);
    assign seg_num  = MUL_W'(seg_diff) * MUL_W'(seg_span);
    assign seg_dvd  = {seg_num, 1'b0} + (MUL_W + 1)'(seg_den);

    // working registers along the sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_load) begin
            r_mean <= div_quot[ADC_W-1:0];
        end
        if (i_cmd.seg_load) begin
            r_below    <= (r_mean <= tab_adc(IDX_W'(0)));
            r_above    <= (r_mean >= tab_adc(IDX_W'(TABLE_POINTS - 1)));
            r_chg_dvd  <= seg_dvd[CHG_BITS-1:0];
            r_chg_dvs  <= DVS_W'({seg_den, 1'b0});
            r_chg_base <= CHARGE_W'(seg_pl) * CHARGE_W'(PCT_SCALE);
            r_mv_dvd   <= MV_DVD_W'(MV_BIAS) + MV_DVD_W'(r_mean) * MV_DVD_W'(MV_SLOPE2);
        end
        if (i_cmd.chg_load) begin
            r_charge <= chg_val;
        end
        if (i_cmd.mv_load) begin
            r_mv  <= (mv_q > MV_W'(r_volt_ofs)) ? mv_q - MV_W'(r_volt_ofs) : '0;
            r_pct <= pct_prod[PCT_SHIFT + PCT_W - 1:PCT_SHIFT];
        end
    end

    // charge: end clamps, then base plus rounded slope term, saturated
    assign chg_sum = (CHARGE_W + 1)'(r_chg_base) + div_quot[CHARGE_W:0];
    always_comb begin
        if (r_above) begin
            chg_val = CHARGE_W'(CHARGE_FULL);
        end else if (r_below) begin
            chg_val = '0;
        end else if (chg_sum > (CHARGE_W + 1)'(CHARGE_FULL)) begin
            chg_val = CHARGE_W'(CHARGE_FULL);
        end else begin
            chg_val = chg_sum[CHARGE_W-1:0];
        end
    end

    // voltage quotient and rounded whole percent
    assign mv_q     = div_quot[MV_W-1:0];
    assign pct_in   = (CHARGE_W + 1)'(r_charge) + (CHARGE_W + 1)'(PCT_RND);
    assign pct_prod = PCT_PROD_W'(pct_in) * PCT_PROD_W'(PCT_RECIP);

    // status from the two thresholds
    always_comb begin
        if (r_charge <= r_crit_thr) begin
            status = ST_CRITICAL;
        end else if (r_charge <= r_low_thr) begin
            status = ST_LOW;
        end else begin
            status = ST_NORMAL;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_adc    <= r_mean;
            r_o_charge <= r_charge;
            r_o_pct    <= r_pct;
            r_o_mv     <= r_mv;
            r_o_status <= status;
        end
    end

    assign o_sts.div_done     = div_done;
    assign o_sts.out_free     = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_filtered_adc      = r_o_adc;
    assign o_charge_hundredths = r_o_charge;
    assign o_charge_percent    = r_o_pct;
    assign o_voltage_mv        = r_o_mv;
    assign o_charge_status     = r_o_status;

    // checks
    `BCE_CHECK_IMPLY(a_div_idle_at_start, i_cmd.div_start, !div_busy)
    `BCE_CHECK_IMPLY(a_mean_count_nonzero, i_cmd.div_start && (i_cmd.div_op == DIV_MEAN), count != '0)
    `BCE_CHECK_IMPLY(a_charge_saturated, r_out_valid, r_o_charge <= CHARGE_W'(CHARGE_FULL))
    `BCE_CHECK_NEXT(a_load_shows_result, i_cmd.out_load, r_out_valid)

endmodule

/* rtl/core/bce_ctrl.sv */
// controller: sequences ring update, three divisions and the result hand-off
module bce_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bce_pkg::t_sts i_sts,
    output bce_pkg::t_cmd o_cmd
);
    import bce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_SEG,
        S_CHG_GO,
        S_CHG_WAIT,
        S_MV_GO,
        S_MV_WAIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_UPD;
            S_UPD:       n_state = S_MEAN_GO;
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: if (i_sts.div_done) n_state = S_SEG;
            S_SEG:       n_state = S_CHG_GO;
            S_CHG_GO:    n_state = S_CHG_WAIT;
            S_CHG_WAIT:  if (i_sts.div_done) n_state = S_MV_GO;
            S_MV_GO:     n_state = S_MV_WAIT;
            S_MV_WAIT:   if (i_sts.div_done) n_state = S_DONE;
            S_DONE:      if (i_sts.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.div_op = DIV_MEAN;
        unique case (r_state)
            S_IDLE:      o_cmd.accept = i_in_valid;
            S_UPD:       o_cmd.upd = 1'b1;
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_MEAN;
            end
            S_MEAN_WAIT: o_cmd.mean_load = i_sts.div_done;
            S_SEG:       o_cmd.seg_load = 1'b1;
            S_CHG_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_CHG;
            end
            S_CHG_WAIT:  o_cmd.chg_load = i_sts.div_done;
            S_MV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_MV;
            end
            S_MV_WAIT:   o_cmd.mv_load = i_sts.div_done;
            S_DONE:      o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* bench/battery_charge_estimator_tb.sv */
// self-checking testbench of the battery charge estimator: directed table, then random runs
module battery_charge_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bce_pkg::*;

    localparam int          RING_SLOTS     = 16;
    localparam int          SOC_POINTS     = 26;
    localparam int unsigned FULL_CHARGE    = 10000;
    localparam longint      MAP_RD_LO      = 2498;
    localparam longint      MAP_RD_HI      = 3720;
    localparam longint      MAP_MV_AT_LO   = 17000;
    localparam longint      MAP_MV_AT_HI   = 25200;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          END_SLACK      = 60;
    localparam int          SHOWN_ERRORS   = 10;
    localparam int          PHASE_ITEMS    = 310;
    localparam int          PLAN_ROWS      = 22;

    // index the block has no register for, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // result word, laid out as on the master side tdata
    typedef struct packed {
        logic [5:0]           pad;
        t_status              status;
        logic [MV_W-1:0]      mv;
        logic [PCT_W-1:0]     pct;
        logic [CHARGE_W-1:0]  charge;
        logic [ADC_W-1:0]     filtered;
    } t_soc_word;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  value;
        int                     reps;
        bit                     typed;
        t_soc_word              word;
    } t_stim_row;

    function automatic t_soc_word soc_word(input int unsigned filtered, input int unsigned charge,
                                           input int unsigned pct, input int unsigned mv,
                                           input t_status status);
        t_soc_word w;
        w          = '0;
        w.filtered = ADC_W'(filtered);
        w.charge   = CHARGE_W'(charge);
        w.pct      = PCT_W'(pct);
        w.mv       = MV_W'(mv);
        w.status   = status;
        return w;
    endfunction

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic                    m_tready = 1'b0;
    logic                    cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    wire                     s_tready;
    wire                     m_tvalid;
    wire  [OUT_TDATA_W-1:0]  m_tdata;

    // charge table: converter reading and percent of each point
    int unsigned soc_rd [SOC_POINTS] = '{
        2802, 2839, 2876, 2913, 2950, 2987, 3024, 3061, 3098, 3135,
        3172, 3209, 3246, 3283, 3320, 3357, 3394, 3431, 3468, 3505,
        3542, 3580, 3620, 3660, 3700, 3720
    };
    int unsigned soc_pct [SOC_POINTS] = '{
        0,  5,  10, 15, 20, 25, 30, 35, 40, 45,
        50, 55, 60, 65, 70, 75, 80, 85, 90, 95,
        100, 100, 100, 100, 100, 100
    };

    // predictor state
    logic [ADC_W-1:0]   ring_q [RING_SLOTS];
    int unsigned        ring_wr   = 0;
    bit                 ring_full = 1'b0;
    logic [THR_W-1:0]   thr_low   = THR_W'(LOW_THR_RST);
    logic [THR_W-1:0]   thr_crit  = THR_W'(CRIT_THR_RST);
    logic [OFS_W-1:0]   mv_ofs    = OFS_W'(VOLT_OFS_RST);

    t_soc_word expected_soc [$];
    int        failures     = 0;
    int        snd_idle_pct = 7;
    int        rcv_idle_pct = 77;
    int        holds_asked  = 0;
    int        holds_done   = 0;
    int        hold_left    = 0;
    int        stall_cycles = 0;

    // directed table: reset values, offset floor, ring extremes, threshold boundaries
    t_stim_row plan [PLAN_ROWS] = '{
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd0,     1,  1'b1, soc_word(0, 0, 0, 198, ST_CRITICAL)},
        '{ROW_WRITE,  CFG_VOLT_OFS, 14'd1023,  1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd0,     1,  1'b1, soc_word(0, 0, 0, 0, ST_CRITICAL)},
        '{ROW_WRITE,  CFG_SPARE,    14'h3FFF,  1,  1'b0, '0},
        '{ROW_WRITE,  CFG_VOLT_OFS, 14'd0,     1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd4095,  16, 1'b1,
          soc_word(4095, 10000, 100, 27716, ST_NORMAL)},
        '{ROW_WRITE,  CFG_CRIT_THR, 14'd10000, 1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd4095,  1,  1'b1,
          soc_word(4095, 10000, 100, 27716, ST_CRITICAL)},
        '{ROW_WRITE,  CFG_CRIT_THR, 14'd9999,  1,  1'b0, '0},
        '{ROW_WRITE,  CFG_LOW_THR,  14'd10000, 1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd4095,  1,  1'b1,
          soc_word(4095, 10000, 100, 27716, ST_LOW)},
        '{ROW_WRITE,  CFG_LOW_THR,  14'h3FFF,  1,  1'b0, '0},
        '{ROW_WRITE,  CFG_CRIT_THR, 14'h3FFF,  1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd4095,  1,  1'b1,
          soc_word(4095, 10000, 100, 27716, ST_CRITICAL)},
        '{ROW_WRITE,  CFG_LOW_THR,  14'd0,     1,  1'b0, '0},
        '{ROW_WRITE,  CFG_CRIT_THR, 14'd0,     1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd2802,  1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd3542,  1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd2803,  1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'd3720,  1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'h0AAA,  1,  1'b0, '0},
        '{ROW_SAMPLE, CFG_LOW_THR,  14'h0555,  1,  1'b0, '0}
    };

    battery_charge_estimator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_wdata     (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // store the sample, average the ring, map to charge, voltage and status
    function automatic t_soc_word step_soc(input logic [ADC_W-1:0] adc);
        int unsigned fill;
        int unsigned total;
        int unsigned mean;
        int unsigned charge;
        int unsigned seg;
        int unsigned span;
        int unsigned rise;
        longint      lin;
        longint      mv;
        t_status     status;
        ring_q[ring_wr] = adc;
        ring_wr = (ring_wr + 1) % RING_SLOTS;
        if (ring_wr == 0) begin
            ring_full = 1'b1;
        end
        fill  = ring_full ? RING_SLOTS : ring_wr;
        total = 0;
        for (int i = 0; i < fill; i++) begin
            total += 32'(ring_q[i]);
        end
        mean = total / fill;

        // piecewise linear charge, rounded half up
        if (mean >= soc_rd[SOC_POINTS-1]) begin
            charge = FULL_CHARGE;
        end else if (mean <= soc_rd[0]) begin
            charge = 0;
        end else begin
            seg = 1;
            while (mean > soc_rd[seg]) seg++;
            span   = soc_rd[seg] - soc_rd[seg-1];
            rise   = (mean - soc_rd[seg-1]) * 100 * (soc_pct[seg] - soc_pct[seg-1]);
            charge = soc_pct[seg-1] * 100 + (2 * rise + span) / (2 * span);
            if (charge > FULL_CHARGE) charge = FULL_CHARGE;
        end

        // linear voltage map, rounded half up, less the offset, floored at zero
        lin = MAP_MV_AT_LO * (MAP_RD_HI - MAP_RD_LO)
              + (longint'(mean) - MAP_RD_LO) * (MAP_MV_AT_HI - MAP_MV_AT_LO);
        if (lin < 0) lin = 0;
        mv = (2 * lin + (MAP_RD_HI - MAP_RD_LO)) / (2 * (MAP_RD_HI - MAP_RD_LO));
        mv = mv - longint'(mv_ofs);
        if (mv < 0) mv = 0;

        if (charge <= 32'(thr_crit)) begin
            status = ST_CRITICAL;
        end else if (charge <= 32'(thr_low)) begin
            status = ST_LOW;
        end else begin
            status = ST_NORMAL;
        end
        return soc_word(mean, charge, (charge + 50) / 100, int'(mv), status);
    endfunction

    // offer one sample request, predict its result once taken
    task automatic send_sample(input logic [ADC_W-1:0] adc, input bit typed,
                               input t_soc_word typed_word);
        t_soc_word predicted;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-ADC_W){1'b0}}, adc};
        do @(posedge clk); while (!s_tready);
        predicted = step_soc(adc);
        expected_soc.push_back(typed ? typed_word : predicted);
    endtask

    // stop offering and wait for every pending result
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_soc.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_LOW_THR:  thr_low  = val[THR_W-1:0];
            CFG_CRIT_THR: thr_crit = val[THR_W-1:0];
            CFG_VOLT_OFS: mv_ofs   = val[OFS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random runs: mostly steady readings around a level, some full range noise
    task automatic run_phase(input int items, input int snd_pct, input int rcv_pct,
                             input bit pressure);
        int sent;
        int run_len;
        int level;
        int spread;
        int v;
        bit steady;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < items) begin
            steady  = ($urandom_range(99) < 80);
            run_len = steady ? int'($urandom_range(8, 40)) : int'($urandom_range(1, 6));
            level   = int'($urandom_range(2650, 3850));
            spread  = int'($urandom_range(0, 24));
            repeat (run_len) begin
                if (steady) begin
                    v = level + int'($urandom_range(0, 2 * spread)) - spread;
                end else begin
                    v = int'($urandom_range(0, 4095));
                end
                send_sample(ADC_W'(v), 1'b0, '0);
                sent++;
                // long receiver hold-off while requests keep coming
                if (pressure && sent == 100) holds_asked++;
                // sender pause until the block has emptied
                if (pressure && sent == 200) wait_drained();
            end
        end
    endtask

    // receiver side ready, with idling and long hold-offs
    always @(negedge clk) begin
        if (hold_left == 0 && holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic void note_field(input string field, input int unsigned want,
                                       input int unsigned got);
        if (want != got) begin
            failures++;
            if (failures <= SHOWN_ERRORS) begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        end
    endfunction

    // compare each result with the oldest pending expectation
    always @(posedge clk) begin : check_results
        t_soc_word got;
        t_soc_word want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_soc.size() == 0) begin
                failures++;
                if (failures <= SHOWN_ERRORS) begin
                    $display("%0t: result with no request pending, tdata %h", $time, m_tdata);
                end
            end else begin
                want = expected_soc.pop_front();
                note_field("filtered_adc", 32'(want.filtered), 32'(got.filtered));
                note_field("charge_hundredths", 32'(want.charge), 32'(got.charge));
                note_field("charge_percent", 32'(want.pct), 32'(got.pct));
                note_field("voltage_mv", 32'(want.mv), 32'(got.mv));
                note_field("charge_status", 32'(want.status), 32'(got.status));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(plan[r].reg_idx, plan[r].value);
            end else begin
                for (int k = 1; k <= plan[r].reps; k++) begin
                    send_sample(plan[r].value[ADC_W-1:0], plan[r].typed && k == plan[r].reps,
                                plan[r].word);
                end
            end
        end

        // reset values back, sender idles rarely, receiver often
        wait_drained();
        write_reg(CFG_LOW_THR, CFG_DATA_W'(LOW_THR_RST));
        write_reg(CFG_CRIT_THR, CFG_DATA_W'(CRIT_THR_RST));
        write_reg(CFG_VOLT_OFS, CFG_DATA_W'(VOLT_OFS_RST));
        run_phase(PHASE_ITEMS, 7, 77, 1'b0);

        // ordered thresholds, sender idles often, receiver rarely
        wait_drained();
        write_reg(CFG_LOW_THR, CFG_DATA_W'($urandom_range(0, 10000)));
        write_reg(CFG_CRIT_THR, CFG_DATA_W'($urandom_range(0, thr_low)));
        write_reg(CFG_VOLT_OFS, CFG_DATA_W'($urandom_range(0, 1000)));
        run_phase(PHASE_ITEMS, 77, 7, 1'b0);

        // unordered thresholds, offset written with junk upper bits, no idling
        wait_drained();
        write_reg(CFG_LOW_THR, CFG_DATA_W'($urandom_range(0, 10000)));
        write_reg(CFG_CRIT_THR, CFG_DATA_W'($urandom_range(0, 10000)));
        write_reg(CFG_VOLT_OFS, CFG_DATA_W'($urandom_range(0, 16383)));
        run_phase(PHASE_ITEMS, 0, 0, 1'b1);

        wait_drained();
        repeat (END_SLACK) @(posedge clk);
        if (failures == 0 && expected_soc.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bce_pkg.sv
rtl/core/bce_div.sv
rtl/core/bce_dp.sv
rtl/core/bce_ctrl.sv
rtl/core/battery_charge_estimator.sv
bench/battery_charge_estimator_tb.sv
